// ----- sv/itb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the integer to base digits converter.
package itb_pkg;

	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = 4;
	localparam int CHUNK_W     = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int BASE_W      = 5;

	localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2D;

	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

	localparam logic [BASE_W-1:0] BASE_RESET = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;       // take a new number, clear the digit stack
		logic step;       // one chunk of the long division
		logic out_minus;  // load the minus sign into the output register
		logic out_digit;  // pop a digit into the output register
	} cmd_t;

	typedef struct packed {
		logic div_done;    // this step finishes one digit
		logic quot_zero;   // quotient left by this step is zero
		logic neg;
		logic last_digit;  // one digit left on the stack
		logic out_free;    // output register can take a beat
	} status_t;

endpackage

// ----- sv/itb_num_if.sv -----
`timescale 1ns / 1ps
// Input channel: one signed number per beat.
interface itb_num_if #(
	parameter int WIDTH = 32
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

// ----- sv/itb_char_if.sv -----
`timescale 1ns / 1ps
// Output channel: one character code per beat, flagged on the last one.
interface itb_char_if;
	logic                        valid;
	logic                        ready;
	logic [itb_pkg::CHAR_W-1:0] char_code;
	logic                        last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- sv/itb_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the converter.
module itb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  itb_pkg::status_t st,
	output itb_pkg::cmd_t    cmd
);

	itb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			itb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = itb_pkg::ST_DIV;
				end
			end
			itb_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (st.div_done && st.quot_zero) begin
					state_d = st.neg ? itb_pkg::ST_SIGN : itb_pkg::ST_EMIT;
				end
			end
			itb_pkg::ST_SIGN: begin
				if (st.out_free) begin
					cmd.out_minus = 1'b1;
					state_d       = itb_pkg::ST_EMIT;
				end
			end
			itb_pkg::ST_EMIT: begin
				if (st.out_free) begin
					cmd.out_digit = 1'b1;
					if (st.last_digit) begin
						state_d = itb_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = itb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/itb_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: configuration, chunked long division, digit stack, output register.
module itb_datapath #(
	parameter int MAX_BASE     = 16,
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  itb_pkg::cmd_t                       cmd,
	output itb_pkg::status_t                    st,
	input  logic signed [NUMBER_WIDTH-1:0]      number,
	input  logic                                cfg_we,
	input  logic [itb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [itb_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [itb_pkg::CHAR_W-1:0]          out_char,
	output logic                                out_last
);

	localparam int NCH   = (NUMBER_WIDTH + itb_pkg::CHUNK_W - 1) / itb_pkg::CHUNK_W;
	localparam int PW    = NCH * itb_pkg::CHUNK_W;
	localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int DEPTH = NUMBER_WIDTH;
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int DW    = itb_pkg::DIGIT_W;
	localparam int BW    = itb_pkg::BASE_W;

	logic [BW-1:0]                   base_len_q;
	logic [itb_pkg::CFG_DATA_W-1:0]  sym_lo_q;
	logic [itb_pkg::CFG_DATA_W-1:0]  sym_hi_q;
	logic [BW-1:0]                   base_eff;

	logic [PW-1:0]           work_q;
	logic [PW-1:0]           work_next;
	logic [DW-1:0]           rem_q;
	logic [DW-1:0]           rem_next;
	logic [itb_pkg::CHUNK_W-1:0] qbits;
	logic [CW-1:0]           chunk_q;
	logic                    chunk_last;
	logic                    neg_q;
	logic [NUMBER_WIDTH-1:0] mag;

	logic [DW-1:0]           stack_q [DEPTH];
	logic [NW-1:0]           count_q;
	logic                    push;

	logic                              out_valid_q;
	logic [itb_pkg::CHAR_W-1:0]        out_char_q;
	logic                              out_last_q;
	logic [2*itb_pkg::CFG_DATA_W-1:0]  syms;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q <= itb_pkg::BASE_RESET;
			sym_lo_q   <= '0;
			sym_hi_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				itb_pkg::CFG_BASE_LENGTH:  base_len_q <= cfg_data[BW-1:0];
				itb_pkg::CFG_SYMBOLS_LOW:  sym_lo_q   <= cfg_data;
				itb_pkg::CFG_SYMBOLS_HIGH: sym_hi_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (base_len_q < itb_pkg::BASE_MIN) begin
			base_eff = itb_pkg::BASE_MIN;
		end else if (base_len_q > BW'(MAX_BASE)) begin
			base_eff = BW'(MAX_BASE);
		end else begin
			base_eff = base_len_q;
		end
	end

	assign mag = number[NUMBER_WIDTH-1] ? (~number + 1'b1) : number;

	// One chunk of restoring division by the base, most significant bit first
	always_comb begin
		logic [DW-1:0] r;
		logic [BW-1:0] t;
		r     = rem_q;
		qbits = '0;
		for (int k = 0; k < itb_pkg::CHUNK_W; k++) begin
			t = {r, work_q[PW-1-k]};
			if (t >= base_eff) begin
				qbits[itb_pkg::CHUNK_W-1-k] = 1'b1;
				r = DW'(t - base_eff);
			end else begin
				r = t[DW-1:0];
			end
		end
		rem_next  = r;
		work_next = (work_q << itb_pkg::CHUNK_W) | PW'(qbits);
	end

	assign chunk_last = (chunk_q == CW'(NCH - 1));
	assign push       = cmd.step && chunk_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load) begin
				chunk_q <= '0;
			end else if (cmd.step) begin
				chunk_q <= chunk_last ? '0 : chunk_q + 1'b1;
			end
			if (cmd.load) begin
				count_q <= '0;
			end else if (push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.out_digit) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= PW'(mag);
			rem_q  <= '0;
			neg_q  <= number[NUMBER_WIDTH-1];
		end else if (cmd.step) begin
			work_q <= work_next;
			rem_q  <= chunk_last ? '0 : rem_next;
		end
	end

	// Digit stack: push at the top, digits come out in reverse order
	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[0] <= rem_next;
			for (int i = 1; i < DEPTH; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (cmd.out_digit) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	assign syms = {sym_hi_q, sym_lo_q};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_minus || cmd.out_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_minus) begin
			out_char_q <= itb_pkg::MINUS_CODE;
			out_last_q <= 1'b0;
		end else if (cmd.out_digit) begin
			out_char_q <= syms[{stack_q[0], 3'b000} +: itb_pkg::CHAR_W];
			out_last_q <= (count_q == NW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	assign st.div_done   = chunk_last;
	assign st.quot_zero  = (work_next == '0);
	assign st.neg        = neg_q;
	assign st.last_digit = (count_q == NW'(1));
	assign st.out_free   = !out_valid_q || out_ready;

endmodule

// ----- sv/integer_to_base_digits.sv -----
`timescale 1ns / 1ps
// Top level of the integer to base digits converter.
//
// Takes one signed number per beat on the numbers channel and sends its text
// in the configured base, one character code per beat on the chars channel,
// most significant digit first. A negative number opens with a minus sign;
// zero gives the symbol of digit 0 alone. last_char marks the final beat.
// Configuration (base length, symbol tables) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// as the block does not enforce this. The number is taken in the idle state;
// the divider then makes 8 quotient bits per cycle, one pass of the chunked
// long division over all 8-bit chunks of the number for each digit. A minus
// sign goes out ahead of the digits, which leave the output register at one
// beat per cycle while the receiver is ready.
// One number is worked at a time; the next one is taken as soon as its last
// character sits in the output register.
// Reset clears the state machine, the output valid flag and the configuration
// (base 2, all symbols zero). When the receiver stalls, the beat holds in the
// output register and the converter waits.
module integer_to_base_digits #(
	parameter int MAX_BASE     = 16,
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	itb_num_if.sink                         numbers,
	itb_char_if.source                      chars,
	input  logic                            cfg_we,
	input  logic [itb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [itb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	itb_pkg::cmd_t    cmd;
	itb_pkg::status_t st;
	logic             in_ready;

	itb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (numbers.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	itb_datapath #(
		.MAX_BASE     (MAX_BASE),
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.number    (numbers.number),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (chars.valid),
		.out_ready (chars.ready),
		.out_char  (chars.char_code),
		.out_last  (chars.last_char)
	);

	assign numbers.ready = in_ready;

endmodule

// ----- tb/sv/itb_text_checker.sv -----
`timescale 1ns / 1ps
// Checker: tracks configuration, predicts each number's text and compares the char beats.
module itb_text_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	itb_num_if                              numbers,
	itb_char_if                             chars,
	input  logic                            cfg_we,
	input  logic [itb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [itb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              fail_count,
	output int                              chars_owed
);
	import itb_pkg::*;

	localparam int NUM_W     = 32;
	localparam int MAX_RADIX = 16;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_beat_t;

	logic [BASE_W-1:0]     radix_reg  = BASE_RESET;
	logic [CFG_DATA_W-1:0] symbols_lo = '0;
	logic [CFG_DATA_W-1:0] symbols_hi = '0;
	char_beat_t            expected_chars[$];
	int                    fails = 0;

	task automatic note(input string msg);
		fails++;
		if (fails <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Queue the text of one number: sign first, then digits most significant first.
	task automatic spell_number(input logic [NUM_W-1:0] raw);
		logic [NUM_W-1:0]        mag;
		logic [2*CFG_DATA_W-1:0] sym_bits;
		int unsigned             radix;
		logic [DIGIT_W-1:0]      digits[$];
		logic [DIGIT_W-1:0]      d;
		char_beat_t              beat;
		mag = raw[NUM_W-1] ? -raw : raw;
		if (radix_reg < BASE_MIN)
			radix = BASE_MIN;
		else if (radix_reg > MAX_RADIX)
			radix = MAX_RADIX;
		else
			radix = radix_reg;
		sym_bits = {symbols_hi, symbols_lo};
		do begin
			digits.push_front(DIGIT_W'(mag % radix));
			mag = mag / radix;
		end while (mag != 0);
		if (raw[NUM_W-1]) begin
			beat.code = MINUS_CODE;
			beat.last = 1'b0;
			expected_chars.push_back(beat);
		end
		while (digits.size() > 0) begin
			d = digits.pop_front();
			beat.code = sym_bits[8*d +: 8];
			beat.last = (digits.size() == 0);
			expected_chars.push_back(beat);
		end
	endtask

	always @(posedge clk) begin : watch
		char_beat_t want;
		if (!arst_n) begin
			radix_reg  = BASE_RESET;
			symbols_lo = '0;
			symbols_hi = '0;
			expected_chars.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BASE_LENGTH:  radix_reg  = cfg_data[BASE_W-1:0];
					CFG_SYMBOLS_LOW:  symbols_lo = cfg_data;
					CFG_SYMBOLS_HIGH: symbols_hi = cfg_data;
					default: ;
				endcase
			end
			if (numbers.valid && numbers.ready)
				spell_number(numbers.number);
			if (chars.valid && chars.ready) begin
				if (expected_chars.size() == 0) begin
					note($sformatf("unexpected char beat: code %h last %b",
						chars.char_code, chars.last_char));
				end else begin
					want = expected_chars.pop_front();
					if (chars.char_code !== want.code || chars.last_char !== want.last)
						note($sformatf("char mismatch: expected code %h last %b, got code %h last %b",
							want.code, want.last, chars.char_code, chars.last_char));
				end
			end
		end
		fail_count <= fails;
		chars_owed <= expected_chars.size();
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, configuration and number stimulus, and the verdict.
module tb_top;
	import itb_pkg::*;

	localparam logic [CFG_DATA_W-1:0] ASCII_LOW  = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_W-1:0] ASCII_HIGH = 64'h4645_4443_4241_3938;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     fail_count;
	int                     chars_owed;
	int                     idle_pct;
	int                     stall_pct;
	int unsigned            radix_now;

	itb_num_if #(.WIDTH(32)) num_ch ();
	itb_char_if              chr_ch ();

	integer_to_base_digits uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.numbers   (num_ch),
		.chars     (chr_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	itb_text_checker text_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.numbers    (num_ch),
		.chars      (chr_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.chars_owed (chars_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		chr_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	task automatic send_number(input logic [31:0] value);
		if ($urandom_range(99) < idle_pct) begin
			num_ch.valid  <= 1'b0;
			num_ch.number <= $urandom;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		num_ch.valid  <= 1'b1;
		num_ch.number <= value;
		do @(posedge clk); while (!num_ch.ready);
	endtask

	// Drop valid and hold until every queued character has gone out.
	task automatic settle();
		num_ch.valid <= 1'b0;
		@(posedge clk);
		while (chars_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [BASE_W-1:0] radix, input logic [CFG_DATA_W-1:0] lo,
			input logic [CFG_DATA_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASE_LENGTH;
		cfg_data  <= {$urandom, 27'($urandom), radix};
		@(posedge clk);
		cfg_index <= CFG_SYMBOLS_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_SYMBOLS_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_now = (radix < 2) ? 2 : (radix > 16) ? 16 : radix;
	endtask

	function automatic logic [31:0] rand_number();
		logic [31:0] v;
		longint      p;
		case ($urandom_range(7))
			0, 1, 2: v = $urandom;
			3: v = $urandom_range(0, 40);
			4: begin
				case ($urandom_range(4))
					0: v = 32'h0000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h8000_0000;
					3: v = 32'h0000_0001;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			5: begin
				// hit digit-count boundaries: a power of the radix or one below it
				p = 1;
				repeat ($urandom_range(1, 31))
					if (p * radix_now <= 64'h8000_0000)
						p = p * radix_now;
				v = 32'(p - $urandom_range(0, 1));
			end
			default: v = $urandom >> $urandom_range(31);
		endcase
		if ($urandom_range(1) == 1)
			v = -v;
		return v;
	endfunction

	initial begin
		logic [BASE_W-1:0]     radix_list[10];
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		radix_list = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd10, 5'd3, 5'd1, 5'd17, 5'd8, 5'd5};
		arst_n        = 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_BASE_LENGTH;
		cfg_data      <= '0;
		num_ch.valid  <= 1'b0;
		num_ch.number <= '0;
		stall_pct     <= 0;
		idle_pct      = 0;
		radix_now     = 2;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: base 2, all symbols zero
		send_number(32'd5);
		send_number(32'hFFFF_FFFF);
		settle();

		set_config(5'd10, ASCII_LOW, ASCII_HIGH);
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'hFFFF_FFFF);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'd10);
		send_number(32'hFFFF_FFF6);
		send_number(32'd9);
		settle();

		set_config(5'd16, ASCII_LOW, ASCII_HIGH);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'h0000_000F);
		send_number(32'hFFFF_FFFF);
		send_number(32'h1234_5678);
		settle();

		// radix below the minimum clamps to 2
		set_config(5'd0, ASCII_LOW, ASCII_HIGH);
		send_number(32'h8000_0000);
		send_number(32'h7FFF_FFFF);
		send_number(32'd0);
		settle();

		// radix above the maximum clamps to 16
		set_config(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
		send_number(32'd1);
		send_number(32'hDEAD_BEEF);
		settle();

		set_config(5'd1, ASCII_LOW, ASCII_HIGH);
		send_number(32'd6);
		settle();

		set_config(5'd17, ASCII_LOW, ASCII_HIGH);
		send_number(32'hFFFF_FFF1);
		settle();

		// alphabet with a minus sign and blanks among the digit symbols
		set_config(5'd3, 64'h0032_2D31_0000_2D30, ASCII_HIGH);
		send_number(32'h8000_0000);
		send_number(32'h7FFF_FFFF);
		settle();

		for (int blk = 0; blk < 10; blk++) begin
			if (blk == 9)
				radix_list[blk] = 5'($urandom_range(0, 31));
			if (blk % 3 == 0) begin
				lo = ASCII_LOW;
				hi = ASCII_HIGH;
			end else begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end
			set_config(radix_list[blk], lo, hi);
			case (blk % 4)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 54; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 54; end
				default: begin idle_pct = 24; stall_pct <= 24; end
			endcase
			for (int i = 0; i < 48; i++) begin
				if (blk == 5 && i == 24)
					settle();
				send_number(rand_number());
			end
			settle();
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0 && chars_owed == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
